/* rtl/ellp_pkg.sv */
`default_nettype none
package ellp_pkg;

  localparam int ROWS_DEF  = 16;
  localparam int COLS_DEF  = 64;
  localparam int WIDTH_DEF = 8;

  localparam int IDX_W = 6;
  localparam int VAL_W = 32;

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;
  localparam logic [1:0] KIND_MUL  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } mac_ctrl_t;

endpackage
`default_nettype wire

/* rtl/ellp_if.sv */
`default_nettype none
interface ellp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         row_index;
  logic [5:0]         col_index;
  logic signed [31:0] operand_value;
  modport source (output valid, kind, row_index, col_index, operand_value, input ready);
  modport sink   (input valid, kind, row_index, col_index, operand_value, output ready);
endinterface

interface ellp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [5:0]         result_row;
  logic [1:0]         status;
  logic               last;
  modport source (output valid, result_value, result_row, status, last, input ready);
  modport sink   (input valid, result_value, result_row, status, last, output ready);
endinterface
`default_nettype wire

/* rtl/ellp_ram.sv */
`default_nettype none
module ellp_ram #(
  parameter int W = 32,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [W-1:0]       rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/ellp_mac.sv */
`default_nettype none
module ellp_mac (
  input  wire logic                signed [31:0] a,
  input  wire logic                signed [31:0] b,
  input  wire ellp_pkg::mac_ctrl_t ctrl,
  input  wire logic                clk,
  output logic                     signed [31:0] sum_sat
);
  logic signed [63:0] prod;
  logic signed [63:0] acc;

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= a * b;
    end
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.acc) begin
      // arithmetic shift floors the Q32.32 product to Q16.16
      acc <= acc + (prod >>> 16);
    end
  end

  always_comb begin
    if (acc > 64'sd2147483647) begin
      sum_sat = 32'sh7fffffff;
    end else if (acc < -64'sd2147483648) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = acc[31:0];
    end
  end
endmodule
`default_nettype wire

/* rtl/ellpack_sparse_matrix_engine_top.sv */
`default_nettype none
// Channel | Dir | Payload
// in_ch   | in  | kind, row_index, col_index, operand_value
// out_ch  | out | result_value, result_row, status, last
//
// Set and read scan one row of the entry RAM up to the slot, a pair at a time; a
// set then shifts the pairs past the slot to insert one or, for a zero value, to
// remove one. Multiply walks the stored pairs row by row, bound by the single
// read port of the entry RAM.
// Synchronous reset clears the row fill counts and the vector valid bits.
// Results sit in an output register; a stalled sink holds the sequencer only
// when a second result is ready to go.
module ellpack_sparse_matrix_engine_top #(
  parameter int ROWS  = ellp_pkg::ROWS_DEF,
  parameter int COLS  = ellp_pkg::COLS_DEF,
  parameter int WIDTH = ellp_pkg::WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ellp_in_if.sink    in_ch,
  ellp_out_if.source out_ch
);
  localparam int ED   = ROWS * WIDTH;
  localparam int EA_W = (ED > 1) ? $clog2(ED) : 1;
  localparam int VA_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RI_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int K_W  = $clog2(WIDTH + 1);
  localparam int EW   = ellp_pkg::IDX_W + ellp_pkg::VAL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LOOK, S_DECIDE, S_SHR, S_SHRW, S_SHL, S_SHLW,
    S_MRD, S_MVEC, S_MMUL, S_MACC, S_EMIT
  } state_t;

  state_t state;
  logic [1:0]  kind_q;
  logic [5:0]  rq, cq;
  logic [31:0] vq, val_q, a_q;
  logic [K_W-1:0] k, n, slot;
  logic        found;
  logic [RI_W-1:0] ri;
  logic [K_W-1:0] fill [ROWS];
  logic [COLS-1:0] vvalid;
  logic [VA_W-1:0] vcol_q;

  logic [31:0] p_value;
  logic [5:0]  p_row;
  logic [1:0]  p_status;
  logic        p_last;

  logic        ov, olast;
  logic [31:0] ovalue;
  logic [5:0]  orow;
  logic [1:0]  ostatus;

  logic          e_we;
  logic [EA_W-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  logic          v_we;
  logic [VA_W-1:0] v_raddr;
  logic [31:0]   v_rdata;
  logic signed [31:0] mac_b, sum_sat;
  ellp_pkg::mac_ctrl_t mac_ctrl;

  logic [EA_W-1:0] base, mbase;
  logic [RI_W-1:0] rr;
  logic row_ok, col_ok, in_ok;
  logic out_free;

  assign rr      = rq[RI_W-1:0];
  assign base    = EA_W'(rr) * EA_W'(WIDTH);
  assign mbase   = EA_W'(ri) * EA_W'(WIDTH);
  assign row_ok  = {1'b0, in_ch.row_index} < 7'(ROWS);
  assign col_ok  = {1'b0, in_ch.col_index} < 7'(COLS);
  assign in_ok   = in_ch.valid && in_ch.ready;
  assign out_free = !ov || out_ch.ready;

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = ov;
  assign out_ch.result_value = ovalue;
  assign out_ch.result_row   = orow;
  assign out_ch.status       = ostatus;
  assign out_ch.last         = olast;

  // entry RAM addressing and write-back
  always_comb begin
    e_raddr = base + EA_W'(k);
    e_we    = 1'b0;
    e_waddr = base + EA_W'(k);
    e_wdata = e_rdata;
    case (state)
      S_SHR: begin
        e_raddr = base + EA_W'(k) - EA_W'(1);
        if (k == slot) begin
          e_we    = 1'b1;
          e_waddr = base + EA_W'(slot);
          e_wdata = {cq, vq};
        end
      end
      S_SHRW: e_we = 1'b1;
      S_SHL: e_raddr = base + EA_W'(k) + EA_W'(1);
      S_SHLW: e_we = 1'b1;
      S_DECIDE: begin
        if (kind_q == ellp_pkg::KIND_SET && vq != '0 && found) begin
          e_we    = 1'b1;
          e_waddr = base + EA_W'(slot);
          e_wdata = {cq, vq};
        end
      end
      S_MRD: e_raddr = mbase + EA_W'(k);
      default: ;
    endcase
  end

  assign v_we    = in_ok && in_ch.kind == ellp_pkg::KIND_LOAD && col_ok;
  assign v_raddr = VA_W'(e_rdata[EW-1:ellp_pkg::VAL_W]);
  assign mac_b   = vvalid[vcol_q] ? v_rdata : '0;

  always_comb begin
    mac_ctrl.clr = (in_ok && in_ch.kind == ellp_pkg::KIND_MUL) ||
                   (state == S_EMIT && out_free);
    mac_ctrl.mul = (state == S_MMUL);
    mac_ctrl.acc = (state == S_MACC);
  end

  ellp_ram #(.W(EW), .D(ED)) u_ent (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  ellp_ram #(.W(32), .D(COLS)) u_vec (
    .clk(clk), .we(v_we), .waddr(VA_W'(in_ch.col_index)), .wdata(in_ch.operand_value),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  ellp_mac u_mac (
    .a(a_q), .b(mac_b), .ctrl(mac_ctrl), .clk(clk), .sum_sat(sum_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ov     <= 1'b0;
      vvalid <= '0;
      for (int j = 0; j < ROWS; j++) begin
        fill[j] <= '0;
      end
    end else begin
      // drop the beat once taken, unless the emit state reloads it
      if (ov && out_ch.ready && state != S_EMIT) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ok) begin
            kind_q <= in_ch.kind;
            rq     <= in_ch.row_index;
            cq     <= in_ch.col_index;
            vq     <= in_ch.operand_value;
            k      <= '0;
            found  <= 1'b0;
            // a multiply sets last per row
            p_last <= (in_ch.kind != ellp_pkg::KIND_MUL);
            p_row  <= in_ch.row_index;
            p_value <= '0;
            case (in_ch.kind)
              ellp_pkg::KIND_LOAD: begin
                p_row <= '0;
                if (col_ok) begin
                  vvalid[VA_W'(in_ch.col_index)] <= 1'b1;
                  p_value  <= in_ch.operand_value;
                  p_status <= ellp_pkg::ST_OK;
                end else begin
                  p_status <= ellp_pkg::ST_RANGE;
                end
                state <= S_EMIT;
              end
              ellp_pkg::KIND_MUL: begin
                ri    <= '0;
                state <= S_MRD;
              end
              default: begin
                if (row_ok && col_ok) begin
                  n     <= fill[in_ch.row_index[RI_W-1:0]];
                  state <= S_SCAN;
                end else begin
                  p_status <= ellp_pkg::ST_RANGE;
                  state    <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (k == n) begin
            slot  <= n;
            state <= S_DECIDE;
          end else begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          val_q <= e_rdata[ellp_pkg::VAL_W-1:0];
          if (e_rdata[EW-1:ellp_pkg::VAL_W] == cq) begin
            found <= 1'b1;
            slot  <= k;
            state <= S_DECIDE;
          end else if (e_rdata[EW-1:ellp_pkg::VAL_W] > cq) begin
            slot  <= k;
            state <= S_DECIDE;
          end else begin
            k     <= k + K_W'(1);
            state <= S_SCAN;
          end
        end
        S_DECIDE: begin
          p_status <= ellp_pkg::ST_OK;
          state    <= S_EMIT;
          if (kind_q == ellp_pkg::KIND_READ) begin
            if (found) begin
              p_value <= val_q;
            end else begin
              p_status <= ellp_pkg::ST_ABSENT;
            end
          end else if (vq == '0) begin
            if (found) begin
              k     <= slot;
              state <= S_SHL;
            end else begin
              p_status <= ellp_pkg::ST_ABSENT;
            end
          end else if (found) begin
            p_value <= vq;
          end else if (n == K_W'(WIDTH)) begin
            p_status <= ellp_pkg::ST_FULL;
          end else begin
            k     <= n;
            state <= S_SHR;
          end
        end
        S_SHR: begin
          if (k == slot) begin
            fill[rr] <= n + K_W'(1);
            p_value  <= vq;
            state    <= S_EMIT;
          end else begin
            state <= S_SHRW;
          end
        end
        S_SHRW: begin
          k     <= k - K_W'(1);
          state <= S_SHR;
        end
        S_SHL: begin
          if (k + K_W'(1) >= n) begin
            fill[rr] <= n - K_W'(1);
            state    <= S_EMIT;
          end else begin
            state <= S_SHLW;
          end
        end
        S_SHLW: begin
          k     <= k + K_W'(1);
          state <= S_SHL;
        end
        S_MRD: begin
          if (k == fill[ri]) begin
            p_row    <= 6'(ri);
            p_status <= ellp_pkg::ST_OK;
            p_last   <= (ri == RI_W'(ROWS - 1));
            state    <= S_EMIT;
          end else begin
            state <= S_MVEC;
          end
        end
        S_MVEC: begin
          a_q    <= e_rdata[ellp_pkg::VAL_W-1:0];
          vcol_q <= v_raddr;
          state  <= S_MMUL;
        end
        S_MMUL: state <= S_MACC;
        S_MACC: begin
          k     <= k + K_W'(1);
          state <= S_MRD;
        end
        S_EMIT: begin
          if (out_free) begin
            ov      <= 1'b1;
            ovalue  <= (kind_q == ellp_pkg::KIND_MUL) ? sum_sat : p_value;
            orow    <= p_row;
            ostatus <= p_status;
            olast   <= p_last;
            if (kind_q == ellp_pkg::KIND_MUL && !p_last) begin
              ri    <= ri + RI_W'(1);
              k     <= '0;
              state <= S_MRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // row fill of the addressed row never exceeds the row width
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> (n <= K_W'(WIDTH)))
    else $error("row fill above width");

  // entry writes happen only in the update states
  assert property (@(posedge clk) disable iff (rst)
    e_we |-> (state == S_SHR || state == S_SHRW || state == S_SHLW || state == S_DECIDE))
    else $error("entry write outside update");

  // a new output beat is loaded only from the emit state
  assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(state == S_EMIT))
    else $error("result without emit");

  // the vector RAM is never written during a multiply
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MMUL) |-> !v_we)
    else $error("vector write during multiply");
endmodule
`default_nettype wire
